### rtl/serial_frame_handler_defines.svh
// Assertion macros used by the serial frame handler datapath.
// Each macro expects clk_i and rst_ni in the enclosing module.
`ifndef SERIAL_FRAME_HANDLER_DEFINES_SVH
`define SERIAL_FRAME_HANDLER_DEFINES_SVH

`ifndef SYNTH

// Same-cycle implication, checked out of reset.
`define SFH_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define SFH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define SFH_ASSERT_IMPL(lbl, ante, cons, msg)
`define SFH_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

### rtl/sfh_pkg.sv
package sfh_pkg;

  localparam int unsigned PAYLOAD_MAX   = 32;
  localparam int unsigned OVERHEAD      = 5;
  localparam int unsigned MODSTAT_DEPTH = 10;
  localparam int unsigned MOD_FRAME_LEN = 11;

  localparam logic [7:0] HEADER_RESET  = 8'd72;

  // Frame type bytes
  localparam logic [7:0] TYPE_UPLOAD   = 8'h01;
  localparam logic [7:0] TYPE_DOWNLOAD = 8'h02;
  localparam logic [7:0] TYPE_MODULE   = 8'hFE;
  localparam logic [7:0] TYPE_ERROR    = 8'hFF;

  // Error frame codes
  localparam logic [7:0] ERR_CODE_SUM  = 8'h02;
  localparam logic [7:0] ERR_CODE_TYPE = 8'hFF;

  typedef enum logic [2:0] {
    MODE_RX      = 3'd0,
    MODE_UPLOAD  = 3'd1,
    MODE_CTRL    = 3'd2,
    MODE_WR_PAY  = 3'd3,
    MODE_RD_PAY  = 3'd4,
    MODE_RD_STAT = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    KIND_TX     = 2'd0,
    KIND_STATUS = 2'd1,
    KIND_READ   = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    STAT_NONE        = 4'd0,
    STAT_SUM_ERR     = 4'd1,
    STAT_UPLOAD_ACK  = 4'd2,
    STAT_PAYLOAD_UPD = 4'd3,
    STAT_CTRL_ACK    = 4'd4,
    STAT_MOD_UPD     = 4'd5,
    STAT_LAST_ERR    = 4'd6,
    STAT_UNKNOWN     = 4'd7,
    STAT_LEN_ERR     = 4'd8,
    STAT_SENT        = 4'd9
  } status_e;

  // What the decoded item asks of the controller
  typedef enum logic [1:0] {
    ACT_NONE   = 2'd0,
    ACT_SINGLE = 2'd1,
    ACT_FRAME  = 2'd2,
    ACT_MCOPY  = 2'd3
  } act_e;

  typedef struct packed {
    mode_e       mode;
    logic [7:0]  data_byte;
    logic [4:0]  position;
    logic [5:0]  upload_len;
  } item_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  out_byte;
    status_e     status;
    logic        last;
  } result_t;

  typedef struct packed {
    logic capture;  // latch the input transaction
    logic commit;   // apply the decoded item
    logic emit;     // load the next frame byte into the output register
    logic mstep;    // copy one module status byte
    logic mresult;  // load the module update status result
  } cmd_t;

  typedef struct packed {
    act_e act;
    logic slot_free;
    logic frame_last;
    logic mcopy_last;
  } sts_t;

endpackage

### rtl/sfh_ctrl.sv
module sfh_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  sfh_pkg::sts_t sts_i,
  output sfh_pkg::cmd_t cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_EXEC  = 5'b00010,
    S_SEND  = 5'b00100,
    S_MCOPY = 5'b01000,
    S_MRES  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (sts_i.act)
          sfh_pkg::ACT_NONE: begin
            cmd_o.commit = 1'b1;
            state_d      = S_IDLE;
          end
          sfh_pkg::ACT_SINGLE: begin
            // hold until the output register can take the result
            if (sts_i.slot_free) begin
              cmd_o.commit = 1'b1;
              state_d      = S_IDLE;
            end
          end
          sfh_pkg::ACT_FRAME: begin
            cmd_o.commit = 1'b1;
            state_d      = S_SEND;
          end
          sfh_pkg::ACT_MCOPY: begin
            cmd_o.commit = 1'b1;
            state_d      = S_MCOPY;
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_SEND: begin
        if (sts_i.slot_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.frame_last) begin
            state_d = S_IDLE;
          end
        end
      end
      S_MCOPY: begin
        cmd_o.mstep = 1'b1;
        if (sts_i.mcopy_last) begin
          state_d = S_MRES;
        end
      end
      S_MRES: begin
        if (sts_i.slot_free) begin
          cmd_o.mresult = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### rtl/sfh_datapath.sv
`include "serial_frame_handler_defines.svh"

module sfh_datapath #(
  parameter int unsigned PayloadMax = sfh_pkg::PAYLOAD_MAX
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [7:0]       cfg_wdata_i,
  input  sfh_pkg::item_t   in_data_i,
  input  logic             out_stall_i,
  input  sfh_pkg::cmd_t    cmd_i,
  output sfh_pkg::sts_t    sts_o,
  output logic             out_valid_o,
  output sfh_pkg::result_t out_data_o
);

  typedef enum logic [1:0] {
    SRC_ECHO   = 2'd0,
    SRC_UPLOAD = 2'd1,
    SRC_FIXED  = 2'd2
  } src_e;

  localparam int unsigned FrameMax = PayloadMax + sfh_pkg::OVERHEAD;
  localparam int unsigned IdxW     = $clog2(FrameMax);
  localparam int unsigned PayW     = $clog2(PayloadMax);
  localparam int unsigned ModW     = $clog2(sfh_pkg::MODSTAT_DEPTH);
  localparam logic [7:0]  FrameMaxB   = 8'(FrameMax);
  localparam logic [7:0]  OverheadB   = 8'(sfh_pkg::OVERHEAD);
  localparam logic [7:0]  ModLenB     = 8'(sfh_pkg::MOD_FRAME_LEN);
  localparam logic [IdxW-1:0] BodyIdx    = IdxW'(sfh_pkg::OVERHEAD - 1);
  localparam logic [IdxW-1:0] ModLastIdx = IdxW'(sfh_pkg::MOD_FRAME_LEN - 2);

  function automatic sfh_pkg::result_t status_only(sfh_pkg::status_e st);
    sfh_pkg::result_t r;
    r.kind     = sfh_pkg::KIND_STATUS;
    r.out_byte = 8'h00;
    r.status   = st;
    r.last     = 1'b1;
    return r;
  endfunction

  // Captured item and configuration
  sfh_pkg::item_t item_q;
  logic [7:0]     header_q;

  // Receive side
  logic [IdxW-1:0] rx_pos_q, rx_pos_d;
  logic [7:0]      rx_len_q, rx_len_d;
  logic [7:0]      rx_sum_q, rx_sum_d;
  logic [7:0]      rx_type_q;
  logic [7:0]      rx_mem [FrameMax];
  logic [7:0]      rdata_q;

  // Transmit side
  logic [7:0]       frame_cnt_q;
  logic [7:0]       fr_len_q, fr_type_q, fr_arg_q, fr_cnt_q;
  sfh_pkg::status_e fr_status_q;
  src_e             fr_src_q;
  logic [IdxW-1:0]  gi_q, gi_d;
  logic [7:0]       tx_sum_q;

  // Stores
  logic [7:0] pay_q [PayloadMax];
  logic [7:0] mod_q [sfh_pkg::MODSTAT_DEPTH];

  // Output register
  logic             out_valid_q;
  sfh_pkg::result_t out_q;

  // Decode
  logic             p_is1, len_bad, rx_done, pos_in_pay, pos_in_mod;
  logic [7:0]       len_eff;
  sfh_pkg::act_e    act;
  sfh_pkg::result_t sgl;
  logic [7:0]       f_len, f_type, f_arg;
  sfh_pkg::status_e f_status;
  src_e             f_src;

  // Generator and store ports
  logic             last_byte;
  logic [7:0]       tx_byte;
  logic             echo_wr, pay_we;
  logic [PayW-1:0]  pay_addr;
  logic [7:0]       pay_wdata, pay_rdata;
  logic             slot_free, load_out;
  sfh_pkg::result_t out_d;

  assign p_is1      = (rx_pos_q == IdxW'(1));
  assign len_bad    = p_is1 && ((item_q.data_byte < OverheadB) ||
                                (item_q.data_byte > FrameMaxB));
  assign len_eff    = p_is1 ? item_q.data_byte : rx_len_q;
  assign rx_done    = !len_bad && (rx_pos_q >= IdxW'(2)) &&
                      ((8'(rx_pos_q) + 8'd1) >= len_eff);
  assign pos_in_pay = (32'(item_q.position) < PayloadMax);
  assign pos_in_mod = (32'(item_q.position) < sfh_pkg::MODSTAT_DEPTH);

  // One address into the payload store: the frame body while sending,
  // otherwise the item's position.
  assign echo_wr   = cmd_i.emit && (fr_src_q == SRC_ECHO) &&
                     (gi_q >= BodyIdx) && !last_byte;
  assign pay_addr  = cmd_i.emit ? PayW'(gi_q - BodyIdx) : PayW'(item_q.position);
  assign pay_rdata = pay_q[pay_addr];
  assign pay_we    = echo_wr || (cmd_i.commit && (item_q.mode == sfh_pkg::MODE_WR_PAY) &&
                                 pos_in_pay);
  assign pay_wdata = echo_wr ? tx_byte : item_q.data_byte;

  always_comb begin
    act      = sfh_pkg::ACT_NONE;
    sgl      = status_only(sfh_pkg::STAT_NONE);
    f_len    = 8'd7;
    f_type   = sfh_pkg::TYPE_ERROR;
    f_arg    = 8'h00;
    f_status = sfh_pkg::STAT_SENT;
    f_src    = SRC_FIXED;
    unique case (item_q.mode)
      sfh_pkg::MODE_RX: begin
        if (len_bad) begin
          act = sfh_pkg::ACT_SINGLE;
          sgl = status_only(sfh_pkg::STAT_LEN_ERR);
        end else if (rx_done) begin
          if (rx_sum_q != item_q.data_byte) begin
            act      = sfh_pkg::ACT_FRAME;
            f_arg    = sfh_pkg::ERR_CODE_SUM;
            f_status = sfh_pkg::STAT_SUM_ERR;
          end else begin
            unique case (rx_type_q)
              sfh_pkg::TYPE_UPLOAD: begin
                act = sfh_pkg::ACT_SINGLE;
                sgl = status_only(sfh_pkg::STAT_UPLOAD_ACK);
              end
              sfh_pkg::TYPE_DOWNLOAD: begin
                act      = sfh_pkg::ACT_FRAME;
                f_len    = len_eff;
                f_src    = SRC_ECHO;
                f_status = sfh_pkg::STAT_PAYLOAD_UPD;
              end
              sfh_pkg::TYPE_MODULE: begin
                if (len_eff != ModLenB) begin
                  act = sfh_pkg::ACT_SINGLE;
                  sgl = status_only(sfh_pkg::STAT_CTRL_ACK);
                end else begin
                  act = sfh_pkg::ACT_MCOPY;
                end
              end
              sfh_pkg::TYPE_ERROR: begin
                act = sfh_pkg::ACT_SINGLE;
                sgl = status_only(sfh_pkg::STAT_LAST_ERR);
              end
              default: begin
                act      = sfh_pkg::ACT_FRAME;
                f_arg    = sfh_pkg::ERR_CODE_TYPE;
                f_status = sfh_pkg::STAT_UNKNOWN;
              end
            endcase
          end
        end
      end
      sfh_pkg::MODE_UPLOAD: begin
        if (32'(item_q.upload_len) > PayloadMax) begin
          act = sfh_pkg::ACT_SINGLE;
          sgl = status_only(sfh_pkg::STAT_LEN_ERR);
        end else begin
          act    = sfh_pkg::ACT_FRAME;
          f_len  = 8'(item_q.upload_len) + OverheadB;
          f_type = sfh_pkg::TYPE_UPLOAD;
          f_src  = SRC_UPLOAD;
        end
      end
      sfh_pkg::MODE_CTRL: begin
        act    = sfh_pkg::ACT_FRAME;
        f_type = sfh_pkg::TYPE_MODULE;
        f_arg  = item_q.data_byte;
      end
      sfh_pkg::MODE_RD_PAY: begin
        act          = sfh_pkg::ACT_SINGLE;
        sgl.kind     = sfh_pkg::KIND_READ;
        sgl.out_byte = pos_in_pay ? pay_rdata : 8'h00;
      end
      sfh_pkg::MODE_RD_STAT: begin
        act          = sfh_pkg::ACT_SINGLE;
        sgl.kind     = sfh_pkg::KIND_READ;
        sgl.out_byte = pos_in_mod ? mod_q[ModW'(item_q.position)] : 8'h00;
      end
      default: act = sfh_pkg::ACT_NONE;
    endcase
  end

  // Frame byte at the current index; the final byte is the running sum.
  assign last_byte = (8'(gi_q) == (fr_len_q - 8'd1));

  always_comb begin
    if (last_byte) begin
      tx_byte = tx_sum_q;
    end else if (fr_src_q == SRC_ECHO) begin
      tx_byte = rdata_q;
    end else begin
      case (gi_q)
        IdxW'(0): tx_byte = header_q;
        IdxW'(1): tx_byte = fr_len_q;
        IdxW'(2): tx_byte = fr_type_q;
        IdxW'(3): tx_byte = fr_cnt_q;
        BodyIdx:  tx_byte = (fr_src_q == SRC_UPLOAD) ? pay_rdata : fr_arg_q;
        default:  tx_byte = (fr_src_q == SRC_UPLOAD) ? pay_rdata : 8'h00;
      endcase
    end
  end

  // Receive bookkeeping on commit of a received byte
  always_comb begin
    rx_pos_d = rx_pos_q;
    rx_len_d = rx_len_q;
    rx_sum_d = rx_sum_q;
    if (cmd_i.commit && (item_q.mode == sfh_pkg::MODE_RX)) begin
      rx_pos_d = (len_bad || rx_done) ? '0 : rx_pos_q + IdxW'(1);
      rx_len_d = len_eff;
      rx_sum_d = (rx_pos_q == '0) ? item_q.data_byte : rx_sum_q + item_q.data_byte;
    end
  end

  // Frame index; its next value also addresses the receive buffer
  always_comb begin
    gi_d = gi_q;
    if (cmd_i.commit && (act == sfh_pkg::ACT_FRAME)) begin
      gi_d = '0;
    end else if (cmd_i.commit && (act == sfh_pkg::ACT_MCOPY)) begin
      gi_d = BodyIdx;
    end else if (cmd_i.emit || cmd_i.mstep) begin
      gi_d = gi_q + IdxW'(1);
    end
  end

  assign slot_free = !out_valid_q || !out_stall_i;
  assign load_out  = (cmd_i.commit && (act == sfh_pkg::ACT_SINGLE)) ||
                     cmd_i.emit || cmd_i.mresult;

  always_comb begin
    if (cmd_i.emit) begin
      out_d.kind     = sfh_pkg::KIND_TX;
      out_d.out_byte = tx_byte;
      out_d.status   = fr_status_q;
      out_d.last     = last_byte;
    end else if (cmd_i.mresult) begin
      out_d = status_only(sfh_pkg::STAT_MOD_UPD);
    end else begin
      out_d = sgl;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q    <= sfh_pkg::HEADER_RESET;
      rx_pos_q    <= '0;
      rx_len_q    <= '0;
      frame_cnt_q <= '0;
      gi_q        <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < PayloadMax; i++) begin
        pay_q[i] <= '0;
      end
      for (int i = 0; i < sfh_pkg::MODSTAT_DEPTH; i++) begin
        mod_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        header_q <= cfg_wdata_i;
      end
      rx_pos_q <= rx_pos_d;
      rx_len_q <= rx_len_d;
      gi_q     <= gi_d;
      // advance the frame number for every built frame, not for an echo
      if (cmd_i.commit && (act == sfh_pkg::ACT_FRAME) && (f_src != SRC_ECHO)) begin
        frame_cnt_q <= frame_cnt_q + 8'd1;
      end
      if (pay_we) begin
        pay_q[pay_addr] <= pay_wdata;
      end
      if (cmd_i.mstep) begin
        mod_q[ModW'(gi_q - BodyIdx)] <= rdata_q;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= in_data_i;
    end
    rx_sum_q <= rx_sum_d;
    if (cmd_i.commit && (item_q.mode == sfh_pkg::MODE_RX) &&
        (rx_pos_q == IdxW'(2))) begin
      rx_type_q <= item_q.data_byte;
    end
    if (cmd_i.commit && (act == sfh_pkg::ACT_FRAME)) begin
      fr_len_q    <= f_len;
      fr_type_q   <= f_type;
      fr_arg_q    <= f_arg;
      fr_cnt_q    <= frame_cnt_q;
      fr_status_q <= f_status;
      fr_src_q    <= f_src;
      tx_sum_q    <= 8'h00;
    end else if (cmd_i.emit) begin
      tx_sum_q <= tx_sum_q + tx_byte;
    end
    if (load_out) begin
      out_q <= out_d;
    end
  end

  // Receive buffer: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && (item_q.mode == sfh_pkg::MODE_RX)) begin
      rx_mem[rx_pos_q] <= item_q.data_byte;
    end
    rdata_q <= rx_mem[gi_d];
  end

  assign sts_o.act        = act;
  assign sts_o.slot_free  = slot_free;
  assign sts_o.frame_last = last_byte;
  assign sts_o.mcopy_last = (gi_q == ModLastIdx);

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `SFH_ASSERT_IMPL(a_rx_pos_range, 1'b1, 32'(rx_pos_q) < FrameMax, "rx position beyond buffer")
  `SFH_ASSERT_IMPL(a_emit_in_frame, cmd_i.emit, 8'(gi_q) < fr_len_q, "frame index past length")
  `SFH_ASSERT_NEXT(a_last_flag, cmd_i.emit && last_byte, out_valid_q && out_q.last, "lost last")
  `SFH_ASSERT_IMPL(a_mcopy_range, cmd_i.mstep, gi_q >= BodyIdx && gi_q <= ModLastIdx, "mcopy idx")

endmodule

### rtl/serial_frame_handler.sv
// Sequence: a transaction is accepted, then decoded and committed, where a single result enters
//   the output register; a frame's bytes then enter it one by one from the send state.
// Flow: a frame of n bytes (up to 37) or a module status update holds the block until it is done,
//   with the input stalled; the block also waits while the full output register is stalled.
// Reset (asynchronous, active low): receive position, length, frame number and output valid
//   cleared, header byte 72, payload and module status stores zeroed; no clearing pass.
module serial_frame_handler #(
  parameter int unsigned PayloadMax = sfh_pkg::PAYLOAD_MAX
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // configuration: header byte of every built frame
  input  logic             cfg_we_i,
  input  logic [7:0]       cfg_wdata_i,
  // input channel
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  sfh_pkg::item_t   in_data_i,
  // output channel
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output sfh_pkg::result_t out_data_o
);

  // The controller sequences each transaction: capture, decode and commit, then either
  // stream a frame, sweep the module status bytes out of the receive buffer, or drop
  // back to idle. The datapath owns every data register, store and the output register.
  sfh_pkg::cmd_t cmd;
  sfh_pkg::sts_t sts;

  sfh_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // A finished result waits in the output register while the next transaction is taken;
  // a frame advances only on cycles at which that register can be refilled.
  sfh_datapath #(
    .PayloadMax (PayloadMax)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .out_stall_i (out_stall_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule
